@@ hdl/ole_pkg.sv @@
// ---------------------------------------------------------------------------
// ole_pkg
// Shared types, request and status codes for the ordered list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ole_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam int REQ_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 7;
   localparam int COUNT_W  = 7;

   // request kinds
   localparam logic [REQ_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [REQ_W-1:0] OP_REM_FRONT = 3'd3;
   localparam logic [REQ_W-1:0] OP_REM_POS   = 3'd4;
   localparam logic [REQ_W-1:0] OP_SEARCH    = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0]          req_type;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } ole_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FOUND_W-1:0]  found_position;
      logic [COUNT_W-1:0]  count;
   } ole_response_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PLACE,
      S_SHIFT_DN,
      S_SEARCH
   } ole_state_type;

endpackage

@@ hdl/ordered_list_engine.sv @@
// ---------------------------------------------------------------------------
// ordered_list_engine
// Bounded positional list of 32-bit values held in one RAM, with a sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a clock edge where start is high and
//   busy is low; req_data carries the kind, value and 1-based position.
//   Every request produces exactly one result: rsp_valid is high for one
//   cycle with rsp_data (status, found position, count after the request).
//   The receiver cannot stall; the result must be taken in that cycle.
// Sequencing (k = 0-based slot):
//   errors, inserts at the end of the list, removes of the last entry, unused
//   codes and searches of an empty list answer in the next cycle with busy
//   low, so such requests may follow every cycle.
//   insert with a shift: one entry moved per cycle, then the value placed
//   remove with a shift: entries after slot k move one slot to the front
//   search: compares from the front, ends at the first hit or the last entry
//   The rate is set by the single RAM read and write port, which moves or
//   compares one entry per cycle.
// Reset: synchronous, clears the count and the sequencer; the RAM content
//   is not cleared, only entries below the count are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  ole_pkg::ole_request_type  req_data,
   output logic                      rsp_valid,
   output ole_pkg::ole_response_type rsp_data
);

   import ole_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   ole_state_type    state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    tgt_ff, tgt_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ole_response_type rsp_ff, rsp_in;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic [VALUE_W-1:0] mem_rdata;

   // decode of the incoming transaction
   logic               accept;
   logic [STATUS_W-1:0] acc_status;
   logic [CW-1:0]      acc_k;
   logic               acc_write_now;
   logic               acc_drop_now;
   logic               acc_shift_up;
   logic               acc_shift_dn;
   logic               acc_search;
   logic [XW-1:0]      pos_x;
   logic [XW-1:0]      cnt_x;
   logic               is_full;
   logic               is_empty;

   // step flags of the running sequence
   logic up_last;
   logic dn_last;
   logic srch_hit;
   logic srch_last;

   ole_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign accept   = start && (state_ff == S_IDLE);
   assign pos_x    = XW'(req_data.position);
   assign cnt_x    = XW'(count_ff);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      acc_status    = ST_OK;
      acc_k         = '0;
      acc_write_now = 1'b0;
      acc_drop_now  = 1'b0;
      acc_shift_up  = 1'b0;
      acc_shift_dn  = 1'b0;
      acc_search    = 1'b0;
      case (req_data.req_type)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (is_full) begin
               acc_status = ST_FULL;
            end else if (req_data.req_type == OP_INS_POS &&
                         (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
               acc_status = ST_RANGE;
            end else begin
               if (req_data.req_type == OP_INS_FRONT) begin
                  acc_k = '0;
               end else if (req_data.req_type == OP_INS_BACK) begin
                  acc_k = count_ff;
               end else begin
                  acc_k = CW'(pos_x - XW'(1));
               end
               if (acc_k == count_ff) begin
                  acc_write_now = 1'b1;
               end else begin
                  acc_shift_up = 1'b1;
               end
            end
         end
         OP_REM_FRONT, OP_REM_POS: begin
            if (is_empty) begin
               acc_status = ST_EMPTY;
            end else if (req_data.req_type == OP_REM_POS &&
                         (pos_x == '0 || pos_x > cnt_x)) begin
               acc_status = ST_RANGE;
            end else begin
               if (req_data.req_type == OP_REM_FRONT) begin
                  acc_k = '0;
               end else begin
                  acc_k = CW'(pos_x - XW'(1));
               end
               if (acc_k == count_ff - CW'(1)) begin
                  acc_drop_now = 1'b1;
               end else begin
                  acc_shift_dn = 1'b1;
               end
            end
         end
         OP_SEARCH: begin
            if (is_empty) begin
               acc_status = ST_NOTFOUND;
            end else begin
               acc_search = 1'b1;
            end
         end
         default: begin
            acc_status = ST_OK;
         end
      endcase
   end

   assign up_last   = (rd_ptr_ff == tgt_ff);
   assign dn_last   = (CW'(rd_ptr_ff) == count_ff - CW'(1));
   assign srch_hit  = (mem_rdata == value_ff);
   assign srch_last = (CW'(rd_ptr_ff) == count_ff - CW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (acc_shift_up) begin
                  state_in = S_SHIFT_UP;
               end else if (acc_shift_dn) begin
                  state_in = S_SHIFT_DN;
               end else if (acc_search) begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SHIFT_UP: begin
            if (up_last) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = S_IDLE;
         end
         S_SHIFT_DN: begin
            if (dn_last) begin
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (srch_hit || srch_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory control and result
   always_comb begin
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      tgt_in       = tgt_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = rd_ptr_ff + AW'(1);
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = rd_ptr_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_data.value;
               tgt_in   = acc_k[AW-1:0];
               if (acc_write_now) begin
                  mem_we    = 1'b1;
                  mem_waddr = acc_k[AW-1:0];
                  mem_wdata = req_data.value;
                  count_in  = count_ff + CW'(1);
               end else if (acc_drop_now) begin
                  count_in = count_ff - CW'(1);
               end else if (acc_shift_up) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(count_ff - CW'(1));
                  rd_ptr_in = AW'(count_ff - CW'(1));
               end else if (acc_shift_dn) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(acc_k + CW'(1));
                  rd_ptr_in = AW'(acc_k + CW'(1));
               end else if (acc_search) begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  rd_ptr_in = '0;
               end
               if (!(acc_shift_up || acc_shift_dn || acc_search)) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = acc_status;
                  rsp_in.found_position = '0;
                  rsp_in.count          = COUNT_W'(count_in);
               end
            end
         end
         S_SHIFT_UP: begin
            // entry at rd_ptr moves one slot toward the back
            mem_we    = 1'b1;
            mem_waddr = rd_ptr_ff + AW'(1);
            mem_wdata = mem_rdata;
            if (!up_last) begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff - AW'(1);
               rd_ptr_in = rd_ptr_ff - AW'(1);
            end
         end
         S_PLACE: begin
            mem_we                = 1'b1;
            mem_waddr             = tgt_ff;
            mem_wdata             = value_ff;
            count_in              = count_ff + CW'(1);
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_OK;
            rsp_in.found_position = '0;
            rsp_in.count          = COUNT_W'(count_in);
         end
         S_SHIFT_DN: begin
            // entry at rd_ptr moves one slot toward the front
            mem_we    = 1'b1;
            mem_waddr = rd_ptr_ff - AW'(1);
            mem_wdata = mem_rdata;
            if (dn_last) begin
               count_in              = count_ff - CW'(1);
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.found_position = '0;
               rsp_in.count          = COUNT_W'(count_in);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff + AW'(1);
               rd_ptr_in = rd_ptr_ff + AW'(1);
            end
         end
         S_SEARCH: begin
            if (srch_hit) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.found_position = FOUND_W'(CW'(rd_ptr_ff) + CW'(1));
               rsp_in.count          = COUNT_W'(count_ff);
            end else if (srch_last) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_NOTFOUND;
               rsp_in.found_position = '0;
               rsp_in.count          = COUNT_W'(count_ff);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff + AW'(1);
               rd_ptr_in = rd_ptr_ff + AW'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      tgt_ff    <= tgt_in;
      value_ff  <= value_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/ole_ram.sv @@
// ---------------------------------------------------------------------------
// ole_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ole_checker.sv @@
// ---------------------------------------------------------------------------
// ole_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ole_checker #(
   parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input ole_pkg::ole_request_type  req_data,
   input logic                      rsp_valid,
   input ole_pkg::ole_response_type rsp_data
);

   import ole_pkg::*;

   logic accept;
   assign accept = start && !busy && (req_data.req_type == req_data.req_type);

   // an accepted transaction either answers next cycle or keeps the block busy
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor busy");

   // a long operation always ends with its result
   a_busy_end_result : assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // a found position is only reported by a successful search within the list
   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found_position != '0) |->
         (rsp_data.status == ST_OK && rsp_data.found_position <= rsp_data.count))
      else $error("found position without success or beyond count");

   // full and empty results agree with the reported count
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (rsp_data.count == COUNT_W'(CAPACITY)))
      else $error("full status with a count below capacity");

   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |-> (rsp_data.count == '0))
      else $error("empty status with a nonzero count");

endmodule

bind ordered_list_engine ole_checker #(
   .CAPACITY (CAPACITY)
) u_ole_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
